>>> src/macro_argument_splitter_top_assert.svh
// Assertion macros for the macro argument splitter port checker.
`ifndef MACRO_ARGUMENT_SPLITTER_TOP_ASSERT_SVH
`define MACRO_ARGUMENT_SPLITTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mas_pkg.sv
// Types, codes and helpers for the macro argument splitter.
package mas_pkg;

    localparam int POS_BITS_DEF  = 16;
    localparam int NEST_BITS_DEF = 8;

    localparam int CH_W      = 8;
    localparam int ARG_IDX_W = 8;
    localparam int ARG_POS_W = 16;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 8;

    localparam logic [ARG_IDX_W-1:0] ARG_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DECL_PARAMS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_VARIADIC_MODE = CFG_IDX_W'(1);

    // Characters of interest
    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;

    typedef enum logic [2:0] {
        ST_MORE     = 3'd0,
        ST_OK       = 3'd1,
        ST_NOPAREN  = 3'd2,
        ST_ENDED    = 3'd3,
        ST_COUNT    = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_OPEN = 2'd1,
        PH_ARGS = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_DOUBLE = 2'd1,
        Q_SINGLE = 2'd2
    } t_quote;

    typedef enum logic [2:0] {
        EV_IDLE,
        EV_ERROR,
        EV_SEEK_BLANK,
        EV_OPEN,
        EV_CLOSE,
        EV_COMMA,
        EV_CHAR
    } t_event;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            begin_req;
    } t_item;

    typedef struct packed {
        logic [ARG_IDX_W-1:0] decl_params;
        logic                 variadic_mode;
    } t_cfg;

    typedef struct packed {
        logic                 arg_valid;
        logic [ARG_IDX_W-1:0] arg_index;
        logic [ARG_POS_W-1:0] arg_first;
        logic [ARG_POS_W-1:0] arg_end;
        logic                 last;
        t_status              status;
        logic [ARG_POS_W-1:0] next_pos;
    } t_result;

    function automatic logic count_ok(input t_cfg cfg, input logic [ARG_IDX_W-1:0] cnt);
        if (cfg.variadic_mode) begin
            return cnt >= cfg.decl_params;
        end
        return cnt == cfg.decl_params;
    endfunction

endpackage

>>> src/mas_if.sv
// Handshake channels of the macro argument splitter.
interface mas_in_if;
    import mas_pkg::*;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            begin_req;
    modport source(output valid, ch, begin_req, input ready);
    modport sink(input valid, ch, begin_req, output ready);
endinterface

interface mas_out_if;
    import mas_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 arg_valid;
    logic [ARG_IDX_W-1:0] arg_index;
    logic [ARG_POS_W-1:0] arg_first;
    logic [ARG_POS_W-1:0] arg_end;
    logic                 last;
    logic [2:0]           status;
    logic [ARG_POS_W-1:0] next_pos;
    modport source(output valid, arg_valid, arg_index, arg_first, arg_end, last, status,
                   next_pos, input ready);
    modport sink(input valid, arg_valid, arg_index, arg_first, arg_end, last, status,
                 next_pos, output ready);
endinterface

interface mas_cfg_if;
    import mas_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

>>> src/mas_in_reg.sv
// Input register: holds one accepted character request for the scan stage.
module mas_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mas_in_if.sink         i_in,
    input  logic           i_advance,
    output logic           o_valid,
    output mas_pkg::t_item o_item
);
    import mas_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign i_in.ready = !r_valid || i_advance;
    assign o_valid    = r_valid;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= '{ch: i_in.ch, begin_req: i_in.begin_req};
        end
    end
endmodule

>>> src/mas_scan.sv
// Scan state and per-character step logic of the macro argument splitter.
module mas_scan #(
    parameter int POS_BITS  = mas_pkg::POS_BITS_DEF,
    parameter int NEST_BITS = mas_pkg::NEST_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  mas_pkg::t_item   i_item,
    input  mas_pkg::t_cfg    i_cfg,
    output logic             o_res_valid,
    output mas_pkg::t_result o_res
);
    import mas_pkg::*;

    localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
    localparam logic [NEST_BITS-1:0] NEST_MAX = '1;

    t_phase               r_phase, n_phase;
    t_quote               r_quote, n_quote;
    logic                 r_esc, n_esc;
    logic [NEST_BITS-1:0] r_nest, n_nest;
    logic [POS_BITS-1:0]  r_pos, n_pos;
    logic [POS_BITS-1:0]  r_span_start, n_span_start;
    logic [POS_BITS-1:0]  r_span_end, n_span_end;
    logic [ARG_IDX_W-1:0] r_arg_total, n_arg_total;

    // begin_req restarts the scan before this character is looked at
    t_phase               e_phase;
    t_quote               e_quote;
    logic                 e_esc;
    logic [NEST_BITS-1:0] e_nest;
    logic [POS_BITS-1:0]  e_pos, e_span_start, e_span_end, pos_inc;
    logic [ARG_IDX_W-1:0] e_arg_total;

    logic                 blank;
    t_event               ev;
    t_status              err_st;
    t_quote               q_next;
    logic                 esc_next;
    logic [NEST_BITS-1:0] nest_next;
    logic [CH_W-1:0]      ch;

    assign ch           = i_item.ch;
    assign e_phase      = i_item.begin_req ? PH_SEEK : r_phase;
    assign e_quote      = i_item.begin_req ? Q_NONE  : r_quote;
    assign e_esc        = i_item.begin_req ? 1'b0    : r_esc;
    assign e_nest       = i_item.begin_req ? '0      : r_nest;
    assign e_pos        = i_item.begin_req ? '0      : r_pos;
    assign e_span_start = i_item.begin_req ? '0      : r_span_start;
    assign e_span_end   = i_item.begin_req ? '0      : r_span_end;
    assign e_arg_total  = i_item.begin_req ? '0      : r_arg_total;
    assign pos_inc      = e_pos + POS_BITS'(1);
    assign blank        = (ch == CH_SPACE) || (ch == CH_TAB);

    // Classify the character against the current state
    always_comb begin
        ev        = EV_CHAR;
        err_st    = ST_OVERFLOW;
        q_next    = e_quote;
        esc_next  = e_esc;
        nest_next = e_nest;
        if (e_phase == PH_DONE) begin
            ev = EV_IDLE;
        end else if (e_pos == POS_MAX) begin
            ev = EV_ERROR;
        end else if (e_phase == PH_SEEK) begin
            if (blank) begin
                ev = EV_SEEK_BLANK;
            end else if (ch == CH_LPAREN) begin
                ev = EV_OPEN;
            end else begin
                ev     = EV_ERROR;
                err_st = ST_NOPAREN;
            end
        end else if (ch == CH_NUL) begin
            ev     = EV_ERROR;
            err_st = ST_ENDED;
        end else if (e_quote != Q_NONE) begin
            if (e_esc) begin
                esc_next = 1'b0;
            end else if (ch == CH_BSLASH) begin
                esc_next = 1'b1;
            end else if ((e_quote == Q_DOUBLE && ch == CH_DQUOTE) ||
                         (e_quote == Q_SINGLE && ch == CH_SQUOTE)) begin
                q_next = Q_NONE;
            end
        end else if (ch == CH_DQUOTE) begin
            q_next = Q_DOUBLE;
        end else if (ch == CH_SQUOTE) begin
            q_next = Q_SINGLE;
        end else if (ch == CH_LPAREN) begin
            if (e_nest == NEST_MAX) begin
                ev = EV_ERROR;
            end else begin
                nest_next = e_nest + NEST_BITS'(1);
            end
        end else if (ch == CH_RPAREN && e_nest != '0) begin
            nest_next = e_nest - NEST_BITS'(1);
        end else if (ch == CH_RPAREN) begin
            if (e_phase == PH_OPEN) begin
                if (count_ok(i_cfg, '0)) begin
                    ev = EV_CLOSE;
                end else begin
                    ev     = EV_ERROR;
                    err_st = ST_COUNT;
                end
            end else if (e_arg_total == ARG_MAX) begin
                ev = EV_ERROR;
            end else if (!count_ok(i_cfg, e_arg_total + ARG_IDX_W'(1))) begin
                ev     = EV_ERROR;
                err_st = ST_COUNT;
            end else begin
                ev = EV_CLOSE;
            end
        end else if (ch == CH_COMMA && e_nest == '0) begin
            if (e_arg_total == ARG_MAX) begin
                ev = EV_ERROR;
            end else begin
                ev = EV_COMMA;
            end
        end
    end

    // Next state
    always_comb begin
        n_phase      = e_phase;
        n_quote      = e_quote;
        n_esc        = e_esc;
        n_nest       = e_nest;
        n_pos        = e_pos;
        n_span_start = e_span_start;
        n_span_end   = e_span_end;
        n_arg_total  = e_arg_total;
        case (ev)
            EV_IDLE: begin
            end
            EV_ERROR, EV_CLOSE: begin
                n_phase = PH_DONE;
            end
            EV_SEEK_BLANK: begin
                n_pos = pos_inc;
            end
            EV_OPEN: begin
                n_phase      = PH_OPEN;
                n_span_start = pos_inc;
                n_span_end   = pos_inc;
                n_pos        = pos_inc;
            end
            EV_COMMA: begin
                n_phase      = PH_ARGS;
                n_arg_total  = e_arg_total + ARG_IDX_W'(1);
                n_span_start = pos_inc;
                n_span_end   = pos_inc;
                n_pos        = pos_inc;
            end
            EV_CHAR: begin
                n_quote = q_next;
                n_esc   = esc_next;
                n_nest  = nest_next;
                n_pos   = pos_inc;
                if (blank) begin
                    // leading blanks push the empty span forward
                    if (e_span_end == e_span_start) begin
                        n_span_start = pos_inc;
                        n_span_end   = pos_inc;
                    end
                end else begin
                    n_span_end = pos_inc;
                    n_phase    = PH_ARGS;
                end
            end
            default: begin
            end
        endcase
    end

    // Result
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '{default: '0, status: ST_MORE};
        case (ev)
            EV_ERROR: begin
                o_res_valid  = 1'b1;
                o_res.last   = 1'b1;
                o_res.status = err_st;
            end
            EV_CLOSE: begin
                o_res_valid    = 1'b1;
                o_res.last     = 1'b1;
                o_res.status   = ST_OK;
                o_res.next_pos = ARG_POS_W'(pos_inc);
                if (e_phase != PH_OPEN) begin
                    o_res.arg_valid = 1'b1;
                    o_res.arg_index = e_arg_total;
                    o_res.arg_first = ARG_POS_W'(e_span_start);
                    o_res.arg_end   = ARG_POS_W'(e_span_end);
                end
            end
            EV_COMMA: begin
                o_res_valid     = 1'b1;
                o_res.arg_valid = 1'b1;
                o_res.arg_index = e_arg_total;
                o_res.arg_first = ARG_POS_W'(e_span_start);
                o_res.arg_end   = ARG_POS_W'(e_span_end);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SEEK;
            r_quote      <= Q_NONE;
            r_esc        <= 1'b0;
            r_nest       <= '0;
            r_pos        <= '0;
            r_span_start <= '0;
            r_span_end   <= '0;
            r_arg_total  <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_quote      <= n_quote;
            r_esc        <= n_esc;
            r_nest       <= n_nest;
            r_pos        <= n_pos;
            r_span_start <= n_span_start;
            r_span_end   <= n_span_end;
            r_arg_total  <= n_arg_total;
        end
    end
endmodule

>>> src/mas_out_reg.sv
// Result register: holds one result until the sink takes it.
module mas_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mas_pkg::t_result i_res,
    output logic             o_free,
    mas_out_if.source        o_out
);
    import mas_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free          = !r_valid || o_out.ready;
    assign o_out.valid     = r_valid;
    assign o_out.arg_valid = r_res.arg_valid;
    assign o_out.arg_index = r_res.arg_index;
    assign o_out.arg_first = r_res.arg_first;
    assign o_out.arg_end   = r_res.arg_end;
    assign o_out.last      = r_res.last;
    assign o_out.status    = r_res.status;
    assign o_out.next_pos  = r_res.next_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end
endmodule

>>> src/macro_argument_splitter_top.sv
// Macro argument splitter: takes the text after a macro name one character per
// request and reports each argument of a parenthesised invocation as trimmed start
// and end offsets, with a final result carrying the status and the offset after the
// closing parenthesis. A request lands in the input register and is evaluated against
// the scan state there; its result, if any, is loaded into the result register when
// the request advances. One character per cycle is sustained by the single scan stage,
// which updates the state as each request advances; a request that has a result waits
// in the input register only while the sink holds off a full result register.
// begin_req starts a new scan; the user must write configuration between scans, and
// the block itself does not enforce this.
module macro_argument_splitter_top #(
    parameter int POS_BITS  = mas_pkg::POS_BITS_DEF,
    parameter int NEST_BITS = mas_pkg::NEST_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mas_cfg_if.sink   i_cfg,
    mas_in_if.sink    i_in,
    mas_out_if.source o_out
);
    import mas_pkg::*;

    t_cfg    r_cfg;
    logic    item_valid;
    t_item   item;
    logic    res_valid;
    t_result res;
    logic    out_free;
    logic    advance;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_IDX_DECL_PARAMS) begin
                r_cfg.decl_params <= i_cfg.data[ARG_IDX_W-1:0];
            end else if (i_cfg.index == CFG_IDX_VARIADIC_MODE) begin
                r_cfg.variadic_mode <= i_cfg.data[0];
            end
        end
    end

    // Requests without a result never wait on the result register
    assign advance = item_valid && (!res_valid || out_free);

    mas_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (item_valid),
        .o_item    (item)
    );

    mas_scan #(
        .POS_BITS  (POS_BITS),
        .NEST_BITS (NEST_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (advance),
        .i_item      (item),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    mas_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );
endmodule

>>> src/mas_chk.sv
// Port-level checks for the macro argument splitter, bound to the top level.
`include "macro_argument_splitter_top_assert.svh"

module mas_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        arg_valid,
    input logic [7:0]  arg_index,
    input logic [15:0] arg_first,
    input logic [15:0] arg_end,
    input logic        last,
    input logic [2:0]  status,
    input logic [15:0] next_pos
);
    import mas_pkg::*;

    logic        is_err;
    logic        err_shape;
    logic        more_shape;
    logic        span_zero;
    logic        stalled;
    logic [60:0] res_bits;

    assign is_err = (status == ST_NOPAREN) || (status == ST_ENDED) ||
                    (status == ST_COUNT) || (status == ST_OVERFLOW);
    assign err_shape  = last && !arg_valid && (next_pos == '0);
    assign more_shape = arg_valid && (status == ST_MORE);
    assign span_zero  = (arg_index == '0) && (arg_first == '0) && (arg_end == '0);
    assign stalled    = out_valid && !out_ready;
    assign res_bits   = {arg_valid, arg_index, arg_first, arg_end, last, status, next_pos};

    `MAS_ASSERT_IMP(a_err_ends_scan, i_clk, i_rst_n, out_valid && is_err, err_shape, "bad error")
    `MAS_ASSERT_IMP(a_more_has_arg, i_clk, i_rst_n, out_valid && !last, more_shape, "bad span")
    `MAS_ASSERT_IMP(a_no_span_zero, i_clk, i_rst_n, out_valid && !arg_valid, span_zero, "stray span")
    `MAS_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, stalled, out_valid && $stable(res_bits), "moved")
endmodule

bind macro_argument_splitter_top mas_chk u_mas_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .arg_valid (o_out.arg_valid),
    .arg_index (o_out.arg_index),
    .arg_first (o_out.arg_first),
    .arg_end   (o_out.arg_end),
    .last      (o_out.last),
    .status    (o_out.status),
    .next_pos  (o_out.next_pos)
);

>>> tb/arg_span_checker.sv
`timescale 1ns / 100ps
// Span and status predictor for the macro argument splitter, compared against its results.
module arg_span_checker
    import mas_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    mas_cfg_if   i_cfg,
    mas_in_if    i_in,
    mas_out_if   i_out,
    output int   o_failures,
    output int   o_pending,
    output int   o_checked
);

    t_cfg        cfg_shadow;
    t_phase      scan_phase;
    t_quote      quote;
    logic        escaped;
    logic [7:0]  depth;
    logic [15:0] pos;
    logic [15:0] span_lo;
    logic [15:0] span_hi;
    logic [7:0]  arg_count;
    t_result     span_q[$];
    t_result     got_res;
    t_result     want_res;
    int          fail_cnt;
    int          check_cnt;

    function automatic string span_text(input t_result r);
        return $sformatf("valid=%0b index=%0d first=%0d end=%0d last=%0b status=%0d next=%0d",
                         r.arg_valid, r.arg_index, r.arg_first, r.arg_end, r.last,
                         r.status, r.next_pos);
    endfunction

    function automatic logic args_fit(input int n);
        if (cfg_shadow.variadic_mode) begin
            return n >= int'(cfg_shadow.decl_params);
        end
        return n == int'(cfg_shadow.decl_params);
    endfunction

    task automatic restart_scan();
        scan_phase = PH_SEEK;
        quote      = Q_NONE;
        escaped    = 1'b0;
        depth      = '0;
        pos        = '0;
        span_lo    = '0;
        span_hi    = '0;
        arg_count  = '0;
    endtask

    // error or count failure: terminal result with no span
    task automatic close_scan(input t_status st);
        t_result r;
        r          = '0;
        r.last     = 1'b1;
        r.status   = st;
        scan_phase = PH_DONE;
        span_q.push_back(r);
    endtask

    task automatic predict_char(input logic [7:0] c, input logic b);
        t_result r;
        logic    blank;
        r = '0;
        if (b) restart_scan();
        if (scan_phase == PH_DONE) return;
        if (pos == 16'hFFFF) begin
            close_scan(ST_OVERFLOW);
            return;
        end
        blank = (c == CH_SPACE) || (c == CH_TAB);

        if (scan_phase == PH_SEEK) begin
            if (c == CH_LPAREN) begin
                scan_phase = PH_OPEN;
                span_lo    = pos + 16'd1;
                span_hi    = pos + 16'd1;
            end else if (!blank) begin
                close_scan(ST_NOPAREN);
                return;
            end
            pos = pos + 16'd1;
            return;
        end

        // end of text wins over quoting and escapes
        if (c == CH_NUL) begin
            close_scan(ST_ENDED);
            return;
        end

        if (quote != Q_NONE) begin
            if (escaped) begin
                escaped = 1'b0;
            end else if (c == CH_BSLASH) begin
                escaped = 1'b1;
            end else if ((quote == Q_DOUBLE && c == CH_DQUOTE) ||
                         (quote == Q_SINGLE && c == CH_SQUOTE)) begin
                quote = Q_NONE;
            end
        end else if (c == CH_DQUOTE) begin
            quote = Q_DOUBLE;
        end else if (c == CH_SQUOTE) begin
            quote = Q_SINGLE;
        end else if (c == CH_LPAREN) begin
            if (depth == 8'hFF) begin
                close_scan(ST_OVERFLOW);
                return;
            end
            depth = depth + 8'd1;
        end else if (c == CH_RPAREN && depth != 0) begin
            depth = depth - 8'd1;
        end else if (c == CH_RPAREN) begin
            if (scan_phase == PH_OPEN) begin
                if (!args_fit(0)) begin
                    close_scan(ST_COUNT);
                    return;
                end
            end else begin
                if (arg_count == ARG_MAX) begin
                    close_scan(ST_OVERFLOW);
                    return;
                end
                if (!args_fit(int'(arg_count) + 1)) begin
                    close_scan(ST_COUNT);
                    return;
                end
                r.arg_valid = 1'b1;
                r.arg_index = arg_count;
                r.arg_first = span_lo;
                r.arg_end   = span_hi;
            end
            r.last     = 1'b1;
            r.status   = ST_OK;
            r.next_pos = pos + 16'd1;
            scan_phase = PH_DONE;
            span_q.push_back(r);
            return;
        end else if (c == CH_COMMA && depth == 0) begin
            if (arg_count == ARG_MAX) begin
                close_scan(ST_OVERFLOW);
                return;
            end
            r.arg_valid = 1'b1;
            r.arg_index = arg_count;
            r.arg_first = span_lo;
            r.arg_end   = span_hi;
            r.status    = ST_MORE;
            span_q.push_back(r);
            arg_count  = arg_count + 8'd1;
            scan_phase = PH_ARGS;
            span_lo    = pos + 16'd1;
            span_hi    = pos + 16'd1;
            pos        = pos + 16'd1;
            return;
        end

        // leading blanks move the span start, anything else extends the end
        if (blank) begin
            if (span_hi == span_lo) begin
                span_lo = pos + 16'd1;
                span_hi = pos + 16'd1;
            end
        end else begin
            span_hi    = pos + 16'd1;
            scan_phase = PH_ARGS;
        end
        pos = pos + 16'd1;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_shadow = '0;
            restart_scan();
            span_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got_res.arg_valid = i_out.arg_valid;
                got_res.arg_index = i_out.arg_index;
                got_res.arg_first = i_out.arg_first;
                got_res.arg_end   = i_out.arg_end;
                got_res.last      = i_out.last;
                got_res.status    = t_status'(i_out.status);
                got_res.next_pos  = i_out.next_pos;
                if (span_q.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result, expected none, actual %s", $time,
                             span_text(got_res));
                end else begin
                    want_res = span_q.pop_front();
                    check_cnt++;
                    if (got_res !== want_res) begin
                        fail_cnt++;
                        $display("%0t: mismatch, expected %s", $time, span_text(want_res));
                        $display("%0t:           actual   %s", $time, span_text(got_res));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_IDX_DECL_PARAMS) begin
                    cfg_shadow.decl_params = i_cfg.data;
                end else if (i_cfg.index == CFG_IDX_VARIADIC_MODE) begin
                    cfg_shadow.variadic_mode = i_cfg.data[0];
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_char(i_in.ch, i_in.begin_req);
            end
        end
        o_failures <= fail_cnt;
        o_pending  <= span_q.size();
        o_checked  <= check_cnt;
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Stimulus, handshake pacing and verdict for the macro argument splitter.
module tb_top;
    import mas_pkg::*;

    localparam int LAT_WAIT    = 4;
    localparam int END_WAIT    = 10;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int RAND_ITEMS  = 330;
    localparam int RAND_PHASES = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       calm;
    logic       hold_tog;
    logic [7:0] text_q[$];
    int         rand_items;
    int         n_items;
    int         n_scans;
    int         idle_run;
    int         failures;
    int         pending;
    int         checked;

    mas_in_if  in_if();
    mas_out_if out_if();
    mas_cfg_if cfg_if();

    macro_argument_splitter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    arg_span_checker u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg_if),
        .i_in       (in_if),
        .i_out      (out_if),
        .o_failures (failures),
        .o_pending  (pending),
        .o_checked  (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, long hold-off on request
    initial begin
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_tog != hold_seen) begin
                hold_seen = hold_tog;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= calm || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    // stall watchdog: any request moving on any channel counts as progress
    initial begin
        idle_run = 0;
        while (idle_run < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
        end
        $display("tb_top failed");
        $finish;
    end

    // valid is left high on return so back-to-back requests need no toggle
    task automatic send_char(input logic [7:0] c, input logic b);
        while (!calm && $urandom_range(0, 99) < 21) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.ch        <= c;
        in_if.begin_req <= b;
        do @(posedge i_clk); while (!in_if.ready);
        n_items++;
        if (b) n_scans++;
    endtask

    task automatic send_text(input bit restarts);
        int i;
        for (i = 0; i < text_q.size(); i++) begin
            send_char(text_q[i], (i == 0) || (restarts && $urandom_range(0, 199) == 0));
        end
    endtask

    task automatic send_str(input string s, input bit nul_end);
        int i;
        text_q.delete();
        for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
        if (nul_end) text_q.push_back(CH_NUL);
        send_text(1'b0);
    endtask

    task automatic settle(input int extra);
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] count, input logic [7:0] mode_data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_IDX_DECL_PARAMS;
        cfg_if.data  <= count;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.index <= CFG_IDX_VARIADIC_MODE;
        cfg_if.data  <= mode_data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [7:0] any_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
    endfunction

    task automatic add_arg();
        logic [7:0] c;
        logic [7:0] q;
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
                0: text_q.push_back(any_blank());
                1, 2: text_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
                3: begin
                    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                    text_q.push_back(q);
                    repeat ($urandom_range(0, 3)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            text_q.push_back(CH_BSLASH);
                            text_q.push_back(8'($urandom_range(1, 255)));
                        end else begin
                            do c = 8'($urandom_range(1, 255)); while (c == q || c == CH_BSLASH);
                            text_q.push_back(c);
                        end
                    end
                    text_q.push_back(q);
                end
                4: begin
                    text_q.push_back(CH_LPAREN);
                    text_q.push_back(8'h62);
                    text_q.push_back(CH_COMMA);
                    text_q.push_back(any_blank());
                    text_q.push_back(CH_RPAREN);
                end
                default: begin
                    do c = 8'($urandom_range(1, 255));
                    while (c == CH_LPAREN || c == CH_RPAREN || c == CH_COMMA ||
                           c == CH_DQUOTE || c == CH_SQUOTE);
                    text_q.push_back(c);
                end
            endcase
        end
    endtask

    // mostly well-formed calls; some cut short by end of text, some raw noise
    task automatic send_random_scan(input int want_args);
        int kind;
        int nargs;
        int cut;
        int a;
        text_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            if ($urandom_range(0, 1)) text_q.push_back(CH_LPAREN);
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            nargs = ($urandom_range(0, 99) < 60) ? want_args : $urandom_range(0, 6);
            repeat ($urandom_range(0, 2)) text_q.push_back(any_blank());
            text_q.push_back(CH_LPAREN);
            for (a = 0; a < nargs; a++) begin
                if (a > 0) text_q.push_back(CH_COMMA);
                add_arg();
            end
            if (nargs == 0 && $urandom_range(0, 1)) text_q.push_back(any_blank());
            text_q.push_back(CH_RPAREN);
            if (kind < 20) begin
                cut = $urandom_range(0, text_q.size() - 1);
                while (text_q.size() > cut) void'(text_q.pop_back());
                text_q.push_back(CH_NUL);
            end
        end
        rand_items += text_q.size();
        send_text(1'b1);
        // characters after the end of a scan are dropped by the block
        repeat ($urandom_range(0, 2)) send_char(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
    endtask

    initial begin
        int         ph;
        int         want_args;
        logic [7:0] mode_data;

        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.ch         <= '0;
        in_if.begin_req  <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.index     <= '0;
        cfg_if.data      <= '0;
        calm             <= 1'b0;
        hold_tog         <= 1'b0;
        rand_items = 0;
        n_items    = 0;
        n_scans    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: zero parameters, exact count
        send_str("x", 1'b0);
        send_str("", 1'b1);
        send_str("\t ()", 1'b0);
        send_str("(", 1'b1);
        settle(LAT_WAIT);
        write_cfg(8'd3, 8'd0);
        send_str("( a ,'\\'',(b) )", 1'b0);
        send_str("(a)", 1'b0);
        settle(LAT_WAIT);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            want_args    = $urandom_range(0, 4);
            mode_data    = 8'($urandom_range(0, 255));
            mode_data[0] = (ph % 2 == 1);
            write_cfg(8'(want_args), mode_data);
            calm <= (ph == 2);
            if (ph == 5) begin
                // receiver stops while many commas keep arriving
                hold_tog <= ~hold_tog;
                text_q.delete();
                text_q.push_back(CH_LPAREN);
                repeat (40) begin
                    text_q.push_back(8'h61);
                    text_q.push_back(CH_COMMA);
                end
                text_q.push_back(CH_RPAREN);
                send_text(1'b0);
            end
            while (rand_items < RAND_ITEMS * (ph + 1) / RAND_PHASES) begin
                send_random_scan(want_args);
            end
            settle(LAT_WAIT);
        end
        calm <= 1'b0;

        // largest argument count: 255 arguments go out, the 256th overflows
        write_cfg(8'd255, 8'd0);
        text_q.delete();
        text_q.push_back(CH_LPAREN);
        repeat (255) text_q.push_back(CH_COMMA);
        text_q.push_back(CH_RPAREN);
        send_text(1'b0);
        settle(END_WAIT);

        $display("Sent %0d characters in %0d scans: calls, quotes, escapes, nesting, noise,",
                 n_items, n_scans);
        $display("argument-count overflow; %0d results checked against predicted spans.",
                 checked);
        if (failures == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

>>> macro_argument_splitter_top.f
+incdir+src
src/mas_pkg.sv
src/mas_if.sv
src/mas_in_reg.sv
src/mas_scan.sv
src/mas_out_reg.sv
src/macro_argument_splitter_top.sv
src/mas_chk.sv
tb/arg_span_checker.sv
tb/tb_top.sv
